// File: design/pfc_pkg.sv
// Package for the Playfair digraph cipher: request codes, letter constants,
// command and status structs, and small lookup functions.
// No dependencies.
package pfc_pkg;

    typedef enum logic [1:0] {
        REQ_KEY      = 2'd0,
        REQ_KEY_DONE = 2'd1,
        REQ_TEXT     = 2'd2,
        REQ_END      = 2'd3
    } t_req;

    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LETTER_LAST = 5'd25;
    localparam logic [4:0] SQUARE_SIZE = 5'd25;
    localparam logic [2:0] SIDE_LAST   = 3'd4;
    localparam logic [6:0] ASCII_A     = 7'd65;
    localparam logic [2:0] REG_MODE    = 3'd0;

    typedef struct packed {
        logic place_key;
        logic walk_init;
        logic walk_step;
        logic set_ready;
        logic hold_load;
        logic pair_text;
        logic pair_end;
        logic key_read;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic square_ready;
        logic held_valid;
        logic letter_ok;
        logic walk_last;
        logic out_busy;
    } t_status;

    function automatic logic fold_ok(input logic [7:0] code);
        fold_ok = (code >= 8'd65 && code <= 8'd90) || (code >= 8'd97 && code <= 8'd122);
    endfunction

    function automatic logic [4:0] fold_index(input logic [7:0] code);
        logic [7:0] v;
        v = (code >= 8'd97) ? (code - 8'd97) : (code - 8'd65);
        fold_index = (v[4:0] == LETTER_J) ? LETTER_I : v[4:0];
    endfunction

    function automatic logic [2:0] place_row(input logic [4:0] p);
        if (p >= 5'd20)      place_row = 3'd4;
        else if (p >= 5'd15) place_row = 3'd3;
        else if (p >= 5'd10) place_row = 3'd2;
        else if (p >= 5'd5)  place_row = 3'd1;
        else                 place_row = 3'd0;
    endfunction

    function automatic logic [2:0] place_col(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        r = place_row(p);
        base = {r, 2'b00} + {2'b00, r};
        place_col = 3'(p - base);
    endfunction

    function automatic logic [2:0] step_side(input logic [2:0] v, input logic fwd);
        if (fwd) step_side = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
        else     step_side = (v == 3'd0) ? SIDE_LAST : v - 3'd1;
    endfunction

    function automatic logic [4:0] square_addr(input logic [2:0] r, input logic [2:0] c);
        square_addr = {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

// File: design/pfc_ctrl.sv
// Controller state machine for the Playfair cipher: input handshake, key fill
// walk and pair sequencing. Depends on pfc_pkg.
module pfc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_req,
    input  pfc_pkg::t_status  i_status,
    output logic              o_ready,
    output pfc_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (pfc_pkg::t_req'(i_req))
                        pfc_pkg::REQ_KEY: begin
                            o_cmd.place_key = !i_status.square_ready;
                        end
                        pfc_pkg::REQ_KEY_DONE: begin
                            if (!i_status.square_ready) begin
                                o_cmd.walk_init = 1'b1;
                                n_state = S_FILL;
                            end
                        end
                        pfc_pkg::REQ_TEXT: begin
                            if (i_status.square_ready && i_status.letter_ok) begin
                                if (i_status.held_valid) begin
                                    o_cmd.pair_text = 1'b1;
                                    n_state = S_LOOK;
                                end else begin
                                    o_cmd.hold_load = 1'b1;
                                end
                            end
                        end
                        pfc_pkg::REQ_END: begin
                            if (i_status.square_ready && i_status.held_valid) begin
                                o_cmd.pair_end = 1'b1;
                                n_state = S_LOOK;
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    o_cmd.set_ready = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                o_cmd.key_read = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/pfc_dp.sv
// Datapath for the Playfair cipher: key square and letter place memories,
// used flags, held letter, pair lookup and output register. Depends on pfc_pkg.
module pfc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_char,
    input  logic              i_mode,
    input  pfc_pkg::t_cmd     i_cmd,
    input  logic              i_out_ready,
    output pfc_pkg::t_status  o_status,
    output logic              o_out_valid,
    output logic [6:0]        o_first,
    output logic [6:0]        o_second,
    output logic              o_ends
);

    logic [4:0]  r_key_square [25];
    logic [4:0]  r_letter_place [26];
    logic [25:0] r_used;
    logic [4:0]  r_fill;
    logic        r_ready;
    logic [4:0]  r_held;
    logic        r_held_v;
    logic [4:0]  r_walk;
    logic [4:0]  r_pa, r_pb;
    logic        r_ends;
    logic [4:0]  r_x, r_y;
    logic        r_pair_ends;
    logic        r_out_valid;
    logic [6:0]  r_first, r_second;
    logic        r_last;

    logic [4:0] w_v;
    logic       w_ok;
    logic [4:0] w_pv;
    logic       w_pen;
    logic [4:0] w_b;
    logic [2:0] w_r1, w_c1, w_r2, w_c2;
    logic [4:0] w_ax, w_ay;

    assign w_v  = pfc_pkg::fold_index(i_char);
    assign w_ok = pfc_pkg::fold_ok(i_char);

    always_comb begin
        w_pv  = i_cmd.walk_step ? r_walk : w_v;
        w_pen = 1'b0;
        if (i_cmd.place_key && w_ok) begin
            w_pen = 1'b1;
        end else if (i_cmd.walk_step && r_walk != pfc_pkg::LETTER_J) begin
            w_pen = 1'b1;
        end
        w_pen = w_pen && !r_used[w_pv] && (r_fill < pfc_pkg::SQUARE_SIZE);
    end

    assign w_b = (i_cmd.pair_end || w_v == r_held) ? pfc_pkg::LETTER_X : w_v;

    always_comb begin
        w_r1 = pfc_pkg::place_row(r_pa);
        w_c1 = pfc_pkg::place_col(r_pa);
        w_r2 = pfc_pkg::place_row(r_pb);
        w_c2 = pfc_pkg::place_col(r_pb);
        priority if (w_r1 == w_r2) begin
            w_ax = pfc_pkg::square_addr(w_r1, pfc_pkg::step_side(w_c1, i_mode));
            w_ay = pfc_pkg::square_addr(w_r2, pfc_pkg::step_side(w_c2, i_mode));
        end else if (w_c1 == w_c2) begin
            w_ax = pfc_pkg::square_addr(pfc_pkg::step_side(w_r1, i_mode), w_c1);
            w_ay = pfc_pkg::square_addr(pfc_pkg::step_side(w_r2, i_mode), w_c2);
        end else begin
            w_ax = pfc_pkg::square_addr(w_r1, w_c2);
            w_ay = pfc_pkg::square_addr(w_r2, w_c1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pen) begin
            r_key_square[r_fill] <= w_pv;
            r_letter_place[w_pv] <= r_fill;
        end
        if (i_cmd.pair_text || i_cmd.pair_end) begin
            r_pa   <= r_letter_place[r_held];
            r_pb   <= r_letter_place[w_b];
            r_ends <= i_cmd.pair_end;
        end
        if (i_cmd.key_read) begin
            r_x         <= r_key_square[w_ax];
            r_y         <= r_key_square[w_ay];
            r_pair_ends <= r_ends;
        end
        if (i_cmd.out_load) begin
            r_first  <= pfc_pkg::ASCII_A + {2'b00, r_x};
            r_second <= pfc_pkg::ASCII_A + {2'b00, r_y};
            r_last   <= r_pair_ends;
        end
        if (i_cmd.hold_load || i_cmd.pair_text) begin
            r_held <= w_v;
        end
        if (i_cmd.walk_init) begin
            r_walk <= 5'd0;
        end else if (i_cmd.walk_step) begin
            r_walk <= r_walk + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_fill      <= '0;
            r_ready     <= 1'b0;
            r_held_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pen) begin
                r_used[w_pv] <= 1'b1;
                r_fill       <= r_fill + 5'd1;
            end
            if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
            priority if (i_cmd.hold_load) begin
                r_held_v <= 1'b1;
            end else if (i_cmd.pair_text) begin
                r_held_v <= (w_v == r_held);
            end else if (i_cmd.pair_end) begin
                r_held_v <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.square_ready = r_ready;
    assign o_status.held_valid   = r_held_v;
    assign o_status.letter_ok    = w_ok;
    assign o_status.walk_last    = (r_walk == pfc_pkg::LETTER_LAST);
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_first     = r_first;
    assign o_second    = r_second;
    assign o_ends      = r_last;

endmodule

// File: design/playfair_digraph_cipher_top.sv
// Top level of the Playfair digraph cipher: stream ports, register port and
// the mode register. Depends on pfc_pkg, pfc_ctrl and pfc_dp.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser = req_type, tdata = char_code
//  m_axis    out        tdata = first_letter, second_letter; tlast = ends_message
//  apb       in/out     encrypt_mode at byte address 0
//
// A key character or a held text letter is handled in the idle state that accepts
// it. Key done starts the fill walk, which steps one letter of the alphabet per
// cycle. A text pair passes through place read, square read, then load of the output
// register. Reset is synchronous and clears the square fill and held letter.
// A pair waits in its last step while the previous result is not taken.
module playfair_digraph_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] first_letter, [13:7] second_letter, pad
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfc_pkg::t_cmd    w_cmd;
    pfc_pkg::t_status w_status;
    logic             r_mode;
    logic [6:0]       w_first, w_second;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pfc_pkg::REG_MODE[2]) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == pfc_pkg::REG_MODE[2]) begin
            r_mode <= pwdata[0];
        end
    end

    pfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_req    (s_axis_tuser),
        .i_status (w_status),
        .o_ready  (s_axis_tready),
        .o_cmd    (w_cmd)
    );

    pfc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (s_axis_tdata),
        .i_mode      (r_mode),
        .i_cmd       (w_cmd),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_first     (w_first),
        .o_second    (w_second),
        .o_ends      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_second, w_first};

endmodule

// File: tb/playfair_checker.sv
// Scoreboard for the Playfair digraph cipher: tracks the key square and the mode register,
// predicts each ciphered digraph and compares it with the output stream.
// Depends on pfc_pkg.
module playfair_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [6:0] first_letter, [13:7] second_letter, pad
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SIDE = 5;

    typedef struct packed {
        logic [6:0] first;
        logic [6:0] second;
        logic       ends;
    } t_digraph;

    t_digraph   digraph_q[$];
    logic [4:0] key_sq [25];
    logic [4:0] place_of [26];
    logic       letter_taken [26];
    logic [4:0] fill_cnt;
    logic       sq_ready;
    logic [4:0] held;
    logic       held_v;
    logic       enc_mode;
    int         fails = 0;

    function automatic logic letter_of(input logic [7:0] c, output logic [4:0] idx);
        logic [7:0] v;
        idx = 5'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            v = c - 8'd65;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = c - 8'd97;
        end else begin
            return 1'b0;
        end
        idx = (v[4:0] == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : v[4:0];
        return 1'b1;
    endfunction

    task automatic add_letter(input logic [4:0] v);
        if (!letter_taken[v] && fill_cnt < 5'd25) begin
            letter_taken[v] = 1'b1;
            key_sq[fill_cnt] = v;
            place_of[v] = fill_cnt;
            fill_cnt = fill_cnt + 5'd1;
        end
    endtask

    function automatic t_digraph encipher(input logic [4:0] a, input logic [4:0] b,
                                          input logic ends);
        int         pa, pb, r1, c1, r2, c2, sh;
        logic [4:0] x, y;
        t_digraph   d;
        pa = place_of[a];
        pb = place_of[b];
        r1 = pa / SIDE;
        c1 = pa % SIDE;
        r2 = pb / SIDE;
        c2 = pb % SIDE;
        sh = enc_mode ? 1 : SIDE - 1;
        if (r1 == r2) begin
            x = key_sq[r1 * SIDE + (c1 + sh) % SIDE];
            y = key_sq[r2 * SIDE + (c2 + sh) % SIDE];
        end else if (c1 == c2) begin
            x = key_sq[((r1 + sh) % SIDE) * SIDE + c1];
            y = key_sq[((r2 + sh) % SIDE) * SIDE + c2];
        end else begin
            x = key_sq[r1 * SIDE + c2];
            y = key_sq[r2 * SIDE + c1];
        end
        d.first  = pfc_pkg::ASCII_A + {2'b00, x};
        d.second = pfc_pkg::ASCII_A + {2'b00, y};
        d.ends   = ends;
        return d;
    endfunction

    task automatic predict_digraph(input logic [1:0] req, input logic [7:0] code);
        logic [4:0] v;
        logic       ok;
        int         c;
        ok = letter_of(code, v);
        case (pfc_pkg::t_req'(req))
            pfc_pkg::REQ_KEY: begin
                if (!sq_ready && ok) add_letter(v);
            end
            pfc_pkg::REQ_KEY_DONE: begin
                if (!sq_ready) begin
                    for (c = 0; c < 26; c++) begin
                        if (5'(c) != pfc_pkg::LETTER_J) add_letter(5'(c));
                    end
                    sq_ready = 1'b1;
                end
            end
            pfc_pkg::REQ_TEXT: begin
                if (sq_ready && ok) begin
                    if (!held_v) begin
                        held = v;
                        held_v = 1'b1;
                    end else if (v == held) begin
                        digraph_q.push_back(encipher(held, pfc_pkg::LETTER_X, 1'b0));
                    end else begin
                        digraph_q.push_back(encipher(held, v, 1'b0));
                        held_v = 1'b0;
                    end
                end
            end
            default: begin
                if (sq_ready && held_v) begin
                    digraph_q.push_back(encipher(held, pfc_pkg::LETTER_X, 1'b1));
                    held_v = 1'b0;
                end
            end
        endcase
    endtask

    task automatic check_digraph();
        t_digraph got, want;
        got.first  = m_axis_tdata[6:0];
        got.second = m_axis_tdata[13:7];
        got.ends   = m_axis_tlast;
        if (digraph_q.size() == 0) begin
            $display("%0t: unexpected digraph %s%s last=%0b", $time, got.first, got.second,
                     got.ends);
            fails++;
        end else begin
            want = digraph_q.pop_front();
            if (got !== want) begin
                $display("%0t: expected %s%s last=%0b, actual %s%s last=%0b", $time,
                         want.first, want.second, want.ends, got.first, got.second, got.ends);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 26; i++) begin
                letter_taken[i] = 1'b0;
                place_of[i] = 5'd0;
                if (i < 25) key_sq[i] = 5'd0;
            end
            fill_cnt = 5'd0;
            sq_ready = 1'b0;
            held = 5'd0;
            held_v = 1'b0;
            enc_mode = 1'b1;
            digraph_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_digraph();
            if (psel && penable && pwrite && pready && paddr == pfc_pkg::REG_MODE) begin
                enc_mode = pwdata[0];
            end
            if (s_axis_tvalid && s_axis_tready) predict_digraph(s_axis_tuser, s_axis_tdata);
        end
        o_pending <= digraph_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/tb.sv
// Testbench top for the Playfair digraph cipher: clock, reset, stream and register stimulus,
// watchdog and verdict. Depends on pfc_pkg, playfair_digraph_cipher_top and playfair_checker.
module tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 40;
    localparam int STALL_LEN  = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int tx_idle = 0;
    int rx_idle = 0;
    int stall_token = 0;
    logic [7:0] last_code = "A";

    playfair_digraph_cipher_top i_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    playfair_checker i_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : receiver
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        forever begin
            @(posedge i_clk);
            if (stall_token != stall_seen) begin
                stall_seen = stall_token;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= IDLE_LIMIT) begin
                $display("playfair_digraph_cipher_top: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? 8'd65 : 8'd97;
        return base + 8'($urandom_range(25));
    endfunction

    task automatic send_req(input pfc_pkg::t_req req, input logic [7:0] code);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= code;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pfc_pkg::REG_MODE;
        pwdata <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_text(input logic [7:0] code);
        if (code != last_code) last_code = code;
        send_req(pfc_pkg::REQ_TEXT, code);
    endtask

    task automatic random_traffic(input int n, input int stall_at, input int pause_at);
        int r;
        for (int k = 0; k < n; k++) begin
            if (k == stall_at) stall_token++;
            if (k == pause_at) drain_block();
            r = $urandom_range(99);
            if (r < 58) begin
                send_text(any_letter());
            end else if (r < 70) begin
                send_text($urandom_range(1) ? last_code : last_code ^ 8'h20);
            end else if (r < 76) begin
                send_text($urandom_range(1) ? "X" : "x");
            end else if (r < 82) begin
                send_req(pfc_pkg::REQ_TEXT, 8'($urandom_range(255)));
            end else if (r < 93) begin
                send_req(pfc_pkg::REQ_END, 8'($urandom_range(255)));
            end else if (r < 97) begin
                send_req(pfc_pkg::REQ_KEY, 8'($urandom_range(255)));
            end else begin
                send_req(pfc_pkg::REQ_KEY_DONE, 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin : stimulus
        int key_len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle = 21;
        rx_idle = 55;

        // text and end of text before the square is ready
        send_req(pfc_pkg::REQ_TEXT, "Q");
        send_req(pfc_pkg::REQ_END, 8'h00);
        send_req(pfc_pkg::REQ_KEY, "j");
        send_req(pfc_pkg::REQ_KEY, "J");
        send_req(pfc_pkg::REQ_KEY, "I");
        send_req(pfc_pkg::REQ_KEY, "a");
        send_req(pfc_pkg::REQ_KEY, "Z");
        send_req(pfc_pkg::REQ_KEY, "z");
        send_req(pfc_pkg::REQ_KEY, "@");
        send_req(pfc_pkg::REQ_KEY, "[");
        send_req(pfc_pkg::REQ_KEY, 8'h00);
        send_req(pfc_pkg::REQ_KEY, 8'hFF);
        key_len = $urandom_range(24);
        for (int k = 0; k < key_len; k++) begin
            send_req(pfc_pkg::REQ_KEY, ($urandom_range(99) < 85) ? any_letter()
                                                                 : 8'($urandom_range(255)));
        end
        send_req(pfc_pkg::REQ_KEY_DONE, 8'hA5);
        send_req(pfc_pkg::REQ_KEY_DONE, 8'h5A);
        send_req(pfc_pkg::REQ_KEY, "B");
        send_req(pfc_pkg::REQ_END, 8'hFF);
        send_text("A");
        send_text("z");
        send_text("x");
        send_text("X");
        send_req(pfc_pkg::REQ_END, 8'h00);
        send_text("J");
        send_text("i");
        send_text("y");
        send_text("m");
        send_req(pfc_pkg::REQ_TEXT, 8'h7F);
        send_req(pfc_pkg::REQ_END, 8'h00);
        drain_block();

        write_mode(1'b0);
        random_traffic(120, 40, 100);
        send_req(pfc_pkg::REQ_END, 8'h00);
        drain_block();

        tx_idle = 55;
        rx_idle = 21;
        write_mode(1'b1);
        random_traffic(120, 60, -1);
        drain_block();

        tx_idle = 0;
        rx_idle = 0;
        write_mode(1'b0);
        random_traffic(120, -1, 75);
        send_req(pfc_pkg::REQ_END, 8'h00);
        drain_block();

        if (fail_count == 0) begin
            $display("playfair_digraph_cipher_top: match");
        end else begin
            $display("playfair_digraph_cipher_top: mismatch");
        end
        $finish;
    end

endmodule
